// ===== rtl/scancode_remap_alt_tab_filter_assert.svh =====
// Assertion macros shared by the scan-code remapper RTL.
`ifndef SCANCODE_REMAP_ALT_TAB_FILTER_ASSERT_SVH
`define SCANCODE_REMAP_ALT_TAB_FILTER_ASSERT_SVH

`ifndef SYNTHESIS
// expression must hold at every edge out of reset
`define SCRAT_ASSERT(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("scrat: invariant violated");
// condition at one edge implies outcome at the next
`define SCRAT_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("scrat: sequence violated");
`else
`define SCRAT_ASSERT(label, clk, rstn, expr)
`define SCRAT_ASSERT_NEXT(label, clk, rstn, pre, post)
`endif

`endif

// ===== rtl/scrat_pkg.sv =====
// Shared types and constants of the scan-code remapper.
package scrat_pkg;

    localparam logic OP_KEY       = 1'b0;
    localparam logic OP_MAP_WRITE = 1'b1;

    localparam int TABLE_AW    = 9;
    localparam int TABLE_DEPTH = 512;

    // table entry: bit 9 flags an invalid target
    localparam logic [9:0] CODE_INVALID = 10'h200;

    localparam logic [8:0] CODE_TAB      = 9'h00F;
    localparam logic [8:0] CODE_LALT     = 9'h038;
    localparam logic [8:0] CODE_RALT     = 9'h138;
    localparam logic [8:0] CODE_RCTRL    = 9'h11D;
    localparam logic [8:0] CODE_E1_PAUSE = 9'h100;

    localparam logic [7:0]  E1_PAUSE_MAKE = 8'h1D;
    localparam logic [7:0]  RAW_E0_HIGH   = 8'hE0;
    localparam logic [15:0] RAW_E1_PAUSE  = 16'hE11D;
    localparam logic [15:0] RAW_E0_ZERO   = 16'h0100;
    localparam logic [15:0] RAW_MAX       = 16'h01FF;

    // break / make / break of a synthetic release burst
    localparam logic [1:0] PHASE_FIRST = 2'd0;
    localparam logic [1:0] PHASE_MAKE  = 2'd1;
    localparam logic [1:0] PHASE_LAST  = 2'd2;

    typedef struct packed {
        logic [9:0] entry;
        logic       rel;
        logic       mouse;
        logic       e1;
    } queue_item_t;

endpackage

// ===== rtl/scrat_front.sv =====
// Front end: request intake, code conversion, remap table and lookup.
`include "scancode_remap_alt_tab_filter_assert.svh"

module scrat_front #(
    parameter int DEPTH = 4,
    parameter int CW    = 3
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_op,
    input  logic [7:0]             s_make_code,
    input  logic                   s_prefix_e0,
    input  logic                   s_prefix_e1,
    input  logic                   s_is_release,
    input  logic                   s_mouse_held,
    input  logic                   s_capture_wanted,
    input  logic                   s_full_screen,
    input  logic [15:0]            s_remap_source,
    input  logic [15:0]            s_remap_target,
    input  logic [CW-1:0]          q_count,
    output logic                   push_valid,
    output scrat_pkg::queue_item_t push_item
);

    function automatic logic [9:0] to_nine_bit(input logic [15:0] raw);
        logic [15:0] r;
        logic [9:0]  res;
        r = raw;
        if (r[15:8] == scrat_pkg::RAW_E0_HIGH) begin
            r = {8'h01, raw[7:0]};
        end
        if (r == scrat_pkg::RAW_E1_PAUSE) begin
            res = {1'b0, scrat_pkg::CODE_E1_PAUSE};
        end else if (r > scrat_pkg::RAW_MAX || r == scrat_pkg::RAW_E0_ZERO) begin
            res = scrat_pkg::CODE_INVALID;
        end else begin
            res = r[9:0];
        end
        return res;
    endfunction

    logic [9:0] remap_mem [scrat_pkg::TABLE_DEPTH];

    logic                          clr_active_reg;
    logic [scrat_pkg::TABLE_AW-1:0] clr_cnt_reg;
    logic                          s1_valid_reg;
    logic                          s1_rel_reg;
    logic                          s1_mouse_reg;
    logic                          s1_e1_reg;
    logic [9:0]                    rd_data_reg;

    logic                          accept;
    logic                          drop;
    logic                          lookup_ok;
    logic [9:0]                    src_code;
    logic [9:0]                    dst_code;
    logic                          tbl_we;
    logic [scrat_pkg::TABLE_AW-1:0] tbl_waddr;
    logic [9:0]                    tbl_wdata;
    logic                          tbl_re;
    logic [scrat_pkg::TABLE_AW-1:0] tbl_raddr;
    logic [CW:0]                   occupancy;

    assign occupancy = {1'b0, q_count} + {{CW{1'b0}}, s1_valid_reg};
    assign s_ready   = !clr_active_reg && (occupancy < (CW+1)'(DEPTH));
    assign accept    = s_valid && s_ready;

    assign drop = s_capture_wanted && !s_mouse_held && !s_full_screen;

    always_comb begin
        if (s_prefix_e1) begin
            lookup_ok = (s_make_code == scrat_pkg::E1_PAUSE_MAKE);
            tbl_raddr = scrat_pkg::CODE_E1_PAUSE;
        end else begin
            lookup_ok = !(s_prefix_e0 && s_make_code == 8'h00);
            tbl_raddr = {s_prefix_e0, s_make_code};
        end
    end

    assign tbl_re = accept && (s_op == scrat_pkg::OP_KEY) && !drop && lookup_ok;

    assign src_code = to_nine_bit(s_remap_source);
    assign dst_code = to_nine_bit(s_remap_target);

    always_comb begin
        if (clr_active_reg) begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_cnt_reg;
            tbl_wdata = {1'b0, clr_cnt_reg};
        end else begin
            tbl_we    = accept && (s_op == scrat_pkg::OP_MAP_WRITE) && !src_code[9];
            tbl_waddr = src_code[8:0];
            tbl_wdata = dst_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            remap_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re) begin
            rd_data_reg <= remap_mem[tbl_raddr];
        end
    end

    // identity fill after reset, one entry per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end else if (clr_active_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == scrat_pkg::TABLE_AW'(scrat_pkg::TABLE_DEPTH - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= tbl_re;
        end
    end

    always_ff @(posedge aclk) begin
        if (tbl_re) begin
            s1_rel_reg   <= s_is_release;
            s1_mouse_reg <= s_mouse_held;
            s1_e1_reg    <= s_prefix_e1;
        end
    end

    assign push_valid      = s1_valid_reg;
    assign push_item.entry = rd_data_reg;
    assign push_item.rel   = s1_rel_reg;
    assign push_item.mouse = s1_mouse_reg;
    assign push_item.e1    = s1_e1_reg;

    `SCRAT_ASSERT_NEXT(a_map_write_no_push, aclk, aresetn, accept && s_op == scrat_pkg::OP_MAP_WRITE, !s1_valid_reg)
    `SCRAT_ASSERT(a_no_lookup_in_fill, aclk, aresetn, !(clr_active_reg && tbl_re))

endmodule

// ===== rtl/scrat_fifo.sv =====
// Short request queue between front end and back end.
`include "scancode_remap_alt_tab_filter_assert.svh"

module scrat_fifo #(
    parameter int DEPTH = 4,
    parameter int CW    = 3
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push_valid,
    input  scrat_pkg::queue_item_t push_item,
    output logic                   pop_valid,
    output scrat_pkg::queue_item_t pop_item,
    input  logic                   pop,
    output logic [CW-1:0]          count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    scrat_pkg::queue_item_t slot_reg [DEPTH];
    logic [PW-1:0]          wr_ptr_reg;
    logic [PW-1:0]          rd_ptr_reg;
    logic [CW-1:0]          count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] n;
        if (p == PW'(DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + 1'b1;
        end
        return n;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_valid) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push_valid && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push_valid) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_valid = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

    `SCRAT_ASSERT(a_no_overflow, aclk, aresetn, !(push_valid && count_reg == CW'(DEPTH)))
    `SCRAT_ASSERT(a_no_underflow, aclk, aresetn, !(pop && count_reg == '0))

endmodule

// ===== rtl/scrat_back.sv =====
// Back end: Alt/Tab tracking, filter decisions and result sequencing.
`include "scancode_remap_alt_tab_filter_assert.svh"

module scrat_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_wr_data,
    input  logic                   q_valid,
    input  scrat_pkg::queue_item_t q_item,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_pressed,
    output logic [8:0]             m_key_code,
    output logic                   m_last
);

    logic       rctrl_alt_reg;
    logic       left_alt_down_reg;
    logic       right_alt_down_reg;
    logic       tab_down_reg;

    logic       job_active_reg;
    logic [8:0] job_code_reg;
    logic       job_press_reg;
    logic       job_burst_reg;
    logic       job_more_reg;
    logic [1:0] job_phase_reg;

    logic       m_valid_reg;
    logic       m_pressed_reg;
    logic [8:0] m_key_code_reg;
    logic       m_last_reg;

    logic       out_free;
    logic       emit;
    logic       job_last;
    logic       job_free;

    logic       ent_valid;
    logic [8:0] ent_code;
    logic       is_tab;
    logic       is_lalt;
    logic       is_ralt;
    logic       dec_emit;
    logic       dec_burst;
    logic       dec_more;
    logic       dec_press;
    logic [8:0] dec_code;
    logic       left_alt_next;
    logic       right_alt_next;
    logic       tab_next;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = job_active_reg && out_free;
    assign job_last = !job_burst_reg || (job_phase_reg == scrat_pkg::PHASE_LAST && !job_more_reg);
    assign job_free = !job_active_reg || (emit && job_last);
    assign q_pop    = q_valid && job_free;

    always_comb begin
        ent_valid      = !q_item.entry[9];
        ent_code       = q_item.entry[8:0];
        is_tab         = ent_valid && ent_code == scrat_pkg::CODE_TAB;
        is_lalt        = ent_valid && ent_code == scrat_pkg::CODE_LALT;
        is_ralt        = ent_valid && ent_code == scrat_pkg::CODE_RALT;
        dec_emit       = 1'b0;
        dec_burst      = 1'b0;
        dec_more       = 1'b0;
        dec_press      = !q_item.rel;
        dec_code       = ent_code;
        left_alt_next  = left_alt_down_reg;
        right_alt_next = right_alt_down_reg;
        tab_next       = tab_down_reg;
        priority if (q_item.e1) begin
            dec_emit = ent_valid;
        end else if (is_tab && !q_item.rel && !q_item.mouse
                     && (left_alt_down_reg || right_alt_down_reg)) begin
            // Alt-Tab: release whichever Alts are held
            dec_emit       = 1'b1;
            dec_burst      = 1'b1;
            dec_code       = left_alt_down_reg ? scrat_pkg::CODE_LALT : scrat_pkg::CODE_RALT;
            dec_more       = left_alt_down_reg && right_alt_down_reg;
            left_alt_next  = 1'b0;
            right_alt_next = 1'b0;
        end else if ((is_lalt || is_ralt) && !q_item.rel && !q_item.mouse && tab_down_reg) begin
            dec_emit  = 1'b1;
            dec_code  = scrat_pkg::CODE_TAB;
            dec_press = 1'b0;
            tab_next  = 1'b0;
        end else begin
            if (is_tab) begin
                tab_next = !q_item.rel;
            end
            if (is_lalt) begin
                left_alt_next = !q_item.rel;
            end
            if (is_ralt) begin
                right_alt_next = !q_item.rel;
            end
            if (ent_valid && ent_code == scrat_pkg::CODE_RCTRL && rctrl_alt_reg) begin
                dec_code = scrat_pkg::CODE_LALT;
            end
            dec_emit = ent_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rctrl_alt_reg      <= 1'b0;
            left_alt_down_reg  <= 1'b0;
            right_alt_down_reg <= 1'b0;
            tab_down_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                rctrl_alt_reg <= cfg_wr_data;
            end
            if (q_pop) begin
                left_alt_down_reg  <= left_alt_next;
                right_alt_down_reg <= right_alt_next;
                tab_down_reg       <= tab_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_active_reg <= 1'b0;
        end else if (q_pop) begin
            job_active_reg <= dec_emit;
        end else if (emit && job_last) begin
            job_active_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_code_reg  <= dec_code;
            job_press_reg <= dec_press;
            job_burst_reg <= dec_burst;
            job_more_reg  <= dec_more;
            job_phase_reg <= scrat_pkg::PHASE_FIRST;
        end else if (emit && !job_last) begin
            if (job_phase_reg == scrat_pkg::PHASE_LAST) begin
                job_phase_reg <= scrat_pkg::PHASE_FIRST;
                job_code_reg  <= scrat_pkg::CODE_RALT;
                job_more_reg  <= 1'b0;
            end else begin
                job_phase_reg <= job_phase_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_pressed_reg  <= job_burst_reg ? (job_phase_reg == scrat_pkg::PHASE_MAKE)
                                            : job_press_reg;
            m_key_code_reg <= job_code_reg;
            m_last_reg     <= job_last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_pressed  = m_pressed_reg;
    assign m_key_code = m_key_code_reg;
    assign m_last     = m_last_reg;

    `SCRAT_ASSERT_NEXT(a_burst_clears_alts, aclk, aresetn, q_pop && dec_burst, !left_alt_down_reg && !right_alt_down_reg)
    `SCRAT_ASSERT_NEXT(a_job_stays_mid_burst, aclk, aresetn, emit && !job_last, job_active_reg)

endmodule

// ===== rtl/scancode_remap_alt_tab_filter.sv =====
// Top level of the keyboard scan-code remapper with Alt-Tab filter.
// Key requests pass the table read register, the queue and the job register to the
// registered result port. Throughput: one request per cycle while m_ready stays high
// and each yields at most one result; a request that yields more (up to six) holds
// the result sequencer until its last result is sent. Reset: synchronous; afterwards
// an identity fill of all 512 table entries runs with s_ready low, while configuration writes are still taken.
`include "scancode_remap_alt_tab_filter_assert.svh"

module scancode_remap_alt_tab_filter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: right Ctrl sent as left Alt
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_make_code,
    input  logic        s_prefix_e0,
    input  logic        s_prefix_e1,
    input  logic        s_is_release,
    input  logic        s_mouse_held,
    input  logic        s_capture_wanted,
    input  logic        s_full_screen,
    input  logic [15:0] s_remap_source,
    input  logic [15:0] s_remap_target,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_pressed,
    output logic [8:0]  m_key_code,
    output logic        m_last
);

    // queue occupancy counter must hold the depth itself
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                   push_valid;
    scrat_pkg::queue_item_t push_item;
    logic                   q_valid;
    scrat_pkg::queue_item_t q_item;
    logic                   q_pop;
    logic [CW-1:0]          q_count;

    // Front end: takes requests, applies table writes, drops key requests while capture
    // is pending without mouse hold or full screen, or the code cannot be looked up, and
    // reads the remap table for the rest. Admission is credit based on queue room.
    scrat_front #(
        .DEPTH (QUEUE_DEPTH),
        .CW    (CW)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_make_code      (s_make_code),
        .s_prefix_e0      (s_prefix_e0),
        .s_prefix_e1      (s_prefix_e1),
        .s_is_release     (s_is_release),
        .s_mouse_held     (s_mouse_held),
        .s_capture_wanted (s_capture_wanted),
        .s_full_screen    (s_full_screen),
        .s_remap_source   (s_remap_source),
        .s_remap_target   (s_remap_target),
        .q_count          (q_count),
        .push_valid       (push_valid),
        .push_item        (push_item)
    );

    // Looked-up events wait here so the front keeps taking requests while
    // the back end plays out a multi-result burst.
    scrat_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .CW    (CW)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop_item   (q_item),
        .pop        (q_pop),
        .count      (q_count)
    );

    // Back end: Alt/Tab tracking, suppression of Alt-Tab, synthetic
    // releases, right Ctrl translation, and the registered result port.
    scrat_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pressed   (m_pressed),
        .m_key_code  (m_key_code),
        .m_last      (m_last)
    );

    // port-level checks
    `SCRAT_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_key_code) && $stable(m_last))

endmodule

// ===== bench/tb_scancode_remap_alt_tab_filter.sv =====
// Self-checking testbench for the scan-code remapper with Alt-Tab filter.
`timescale 1ns / 1ps

module tb_scancode_remap_alt_tab_filter;

    localparam int NUM_DIRECTED     = 26;
    localparam int RANDOM_PER_PHASE = 28;
    // a request yields up to six results in a row
    localparam int SETTLE_CYCLES    = 24;
    // cycles without any handshake: covers the table fill plus long stalls, with margin
    localparam int STALL_LIMIT      = 4000;

    // right Ctrl as left Alt, one bit per random phase (first phase is bit 0)
    localparam logic [2:0] SETTING_PLAN = 3'b101;

    localparam logic [7:0] MAKE_TAB  = 8'h0F;
    localparam logic [7:0] MAKE_ALT  = 8'h38;
    localparam logic [7:0] MAKE_CTRL = 8'h1D;

    // directed rows either carry the result typed in or leave it to the predictor
    localparam bit TYPED      = 1'b1;
    localparam bit PREDICTED  = 1'b0;
    localparam bit ONE_RESULT = 1'b1;
    localparam bit NO_RESULT  = 1'b0;

    typedef struct packed {
        logic        op;
        logic [7:0]  make_code;
        logic        e0;
        logic        e1;
        logic        rel;
        logic        mouse;
        logic        want;
        logic        full;
        logic [15:0] src;
        logic [15:0] tgt;
    } key_req_t;

    typedef struct packed {
        logic       pressed;
        logic [8:0] key_code;
        logic       last;
    } key_out_t;

    typedef struct packed {
        key_req_t   req;
        logic       typed;
        logic       has_result;
        logic [8:0] code;
    } stim_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;

    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic        s_op             = scrat_pkg::OP_KEY;
    logic [7:0]  s_make_code      = '0;
    logic        s_prefix_e0      = 1'b0;
    logic        s_prefix_e1      = 1'b0;
    logic        s_is_release     = 1'b0;
    logic        s_mouse_held     = 1'b0;
    logic        s_capture_wanted = 1'b0;
    logic        s_full_screen    = 1'b0;
    logic [15:0] s_remap_source   = '0;
    logic [15:0] s_remap_target   = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_pressed;
    logic [8:0]  m_key_code;
    logic        m_last;

    // predictor state: remap table, held keys, configuration
    logic [9:0] key_map [0:scrat_pkg::TABLE_DEPTH-1];
    logic       left_alt_held;
    logic       right_alt_held;
    logic       tab_held;
    logic       rctrl_to_lalt;

    key_out_t   pending_keys [$];
    int         mismatches = 0;
    int         quiet_cycles = 0;

    stim_row_t  directed [NUM_DIRECTED];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    scancode_remap_alt_tab_filter i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_make_code      (s_make_code),
        .s_prefix_e0      (s_prefix_e0),
        .s_prefix_e1      (s_prefix_e1),
        .s_is_release     (s_is_release),
        .s_mouse_held     (s_mouse_held),
        .s_capture_wanted (s_capture_wanted),
        .s_full_screen    (s_full_screen),
        .s_remap_source   (s_remap_source),
        .s_remap_target   (s_remap_target),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pressed        (m_pressed),
        .m_key_code       (m_key_code),
        .m_last           (m_last)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // raw 16-bit code to table form; bit 9 set means no usable code
    function automatic logic [9:0] nine_bit_code(input logic [15:0] raw);
        logic [15:0] r;
        r = raw;
        if (r[15:8] == scrat_pkg::RAW_E0_HIGH) begin
            r = {8'h01, r[7:0]};
        end
        if (r == scrat_pkg::RAW_E1_PAUSE) begin
            return {1'b0, scrat_pkg::CODE_E1_PAUSE};
        end
        if (r > scrat_pkg::RAW_MAX || r == scrat_pkg::RAW_E0_ZERO) begin
            return scrat_pkg::CODE_INVALID;
        end
        return r[9:0];
    endfunction

    task automatic queue_key(input logic pressed, input logic [8:0] code);
        key_out_t k;
        k.pressed  = pressed;
        k.key_code = code;
        k.last     = 1'b0;
        pending_keys.push_back(k);
    endtask

    // break, make, break of a released Alt
    task automatic queue_alt_burst(input logic [8:0] code);
        queue_key(1'b0, code);
        queue_key(1'b1, code);
        queue_key(1'b0, code);
    endtask

    // works out the key events a request causes and updates the tracked state
    task automatic remap_and_filter(input key_req_t rq);
        logic [9:0] src;
        logic [9:0] dst;
        logic [9:0] code;
        logic       press;
        int         first;
        key_out_t   tail;
        first = pending_keys.size();
        press = !rq.rel;
        if (rq.op == scrat_pkg::OP_MAP_WRITE) begin
            src = nine_bit_code(rq.src);
            dst = nine_bit_code(rq.tgt);
            if (src != scrat_pkg::CODE_INVALID) begin
                key_map[src[8:0]] = dst;
            end
        end else if (rq.want && !rq.mouse && !rq.full) begin
            // waiting for capture: swallowed whole
        end else if (rq.e1) begin
            // only E1 1D (Pause) is known; no Alt/Tab tracking here
            code = (rq.make_code == scrat_pkg::E1_PAUSE_MAKE)
                 ? key_map[scrat_pkg::CODE_E1_PAUSE] : scrat_pkg::CODE_INVALID;
            if (code != scrat_pkg::CODE_INVALID) begin
                queue_key(press, code[8:0]);
            end
        end else begin
            code = nine_bit_code({7'd0, rq.e0, rq.make_code});
            if (code != scrat_pkg::CODE_INVALID) begin
                code = key_map[code[8:0]];
            end
            if (code == scrat_pkg::CODE_TAB && press && (left_alt_held || right_alt_held)
                    && !rq.mouse) begin
                // Tab under Alt: drop it, let go of every held Alt
                if (left_alt_held) begin
                    queue_alt_burst(scrat_pkg::CODE_LALT);
                    left_alt_held = 1'b0;
                end
                if (right_alt_held) begin
                    queue_alt_burst(scrat_pkg::CODE_RALT);
                    right_alt_held = 1'b0;
                end
            end else if ((code == scrat_pkg::CODE_LALT || code == scrat_pkg::CODE_RALT)
                    && press && tab_held && !rq.mouse) begin
                // Alt under Tab: drop it, release Tab instead
                queue_key(1'b0, scrat_pkg::CODE_TAB);
                tab_held = 1'b0;
            end else begin
                if (code == scrat_pkg::CODE_TAB) begin
                    tab_held = press;
                end else if (code == scrat_pkg::CODE_LALT) begin
                    left_alt_held = press;
                end else if (code == scrat_pkg::CODE_RALT) begin
                    right_alt_held = press;
                end
                if (code == scrat_pkg::CODE_RCTRL && rctrl_to_lalt) begin
                    code = {1'b0, scrat_pkg::CODE_LALT};
                end
                if (code != scrat_pkg::CODE_INVALID) begin
                    queue_key(press, code[8:0]);
                end
            end
        end
        if (pending_keys.size() > first) begin
            tail = pending_keys.pop_back();
            tail.last = 1'b1;
            pending_keys.push_back(tail);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic stim_row_t key_row(input logic [7:0] mk, input logic e0, input logic e1,
                                          input logic rel, input logic mouse, input logic want,
                                          input logic full, input logic typed,
                                          input logic has_result, input logic [8:0] code);
        stim_row_t row;
        row.req            = '0;
        row.req.op         = scrat_pkg::OP_KEY;
        row.req.make_code  = mk;
        row.req.e0         = e0;
        row.req.e1         = e1;
        row.req.rel        = rel;
        row.req.mouse      = mouse;
        row.req.want       = want;
        row.req.full       = full;
        row.typed          = typed;
        row.has_result     = has_result;
        row.code           = code;
        return row;
    endfunction

    // table writes never give a result, so they are always typed in
    function automatic stim_row_t map_row(input logic [15:0] src, input logic [15:0] tgt);
        stim_row_t row;
        row.req        = '0;
        row.req.op     = scrat_pkg::OP_MAP_WRITE;
        row.req.src    = src;
        row.req.tgt    = tgt;
        row.typed      = TYPED;
        row.has_result = NO_RESULT;
        row.code       = '0;
        return row;
    endfunction

    // raw code for a table write: mostly well formed, sometimes anything
    function automatic logic [15:0] raw_code_pick();
        logic [7:0] b;
        b = 8'($urandom);
        case ($urandom_range(0, 5))
            0: return {scrat_pkg::RAW_E0_HIGH, b};
            1: return {8'h00, b};
            2: return {8'h01, b};
            3: return scrat_pkg::RAW_E1_PAUSE;
            4: return {8'h00, ($urandom_range(0, 1) == 0) ? MAKE_TAB : MAKE_ALT};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic key_req_t random_request();
        key_req_t rq;
        rq.op        = scrat_pkg::OP_KEY;
        rq.make_code = 8'($urandom);
        rq.e0        = 1'($urandom);
        rq.e1        = 1'($urandom);
        rq.rel       = 1'($urandom);
        rq.mouse     = 1'($urandom);
        rq.want      = 1'($urandom);
        rq.full      = 1'($urandom);
        rq.src       = 16'($urandom);
        rq.tgt       = 16'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            rq.op  = scrat_pkg::OP_MAP_WRITE;
            rq.src = raw_code_pick();
            rq.tgt = raw_code_pick();
            // now and then put an entry back to identity
            if ($urandom_range(0, 3) == 0) begin
                rq.tgt = rq.src;
            end
        end else begin
            // lean on Tab, Alt and Ctrl so the filter sees real sequences
            case ($urandom_range(0, 5))
                0, 1: rq.make_code = MAKE_TAB;
                2, 3: rq.make_code = MAKE_ALT;
                4:    rq.make_code = MAKE_CTRL;
                default: ;
            endcase
            rq.e0    = ($urandom_range(0, 2) == 0);
            rq.e1    = ($urandom_range(0, 15) == 0);
            rq.rel   = ($urandom_range(0, 2) == 0);
            rq.mouse = ($urandom_range(0, 3) == 0);
            rq.want  = ($urandom_range(0, 5) == 0);
            rq.full  = ($urandom_range(0, 2) == 0);
        end
        return rq;
    endfunction

    // idle cycles before the next handshake; runs of no idling now and then
    function automatic int draw_pause(inout int run_left, inout bit busy_run);
        if (run_left == 0) begin
            busy_run = ($urandom_range(0, 3) == 0);
            run_left = $urandom_range(8, 24);
        end
        run_left--;
        return busy_run ? 0 : $urandom_range(0, 15);
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // holds the request until accepted; valid only drops when a gap follows
    task automatic offer_request(input key_req_t rq, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_op             <= rq.op;
        s_make_code      <= rq.make_code;
        s_prefix_e0      <= rq.e0;
        s_prefix_e1      <= rq.e1;
        s_is_release     <= rq.rel;
        s_mouse_held     <= rq.mouse;
        s_capture_wanted <= rq.want;
        s_full_screen    <= rq.full;
        s_remap_source   <= rq.src;
        s_remap_target   <= rq.tgt;
        s_valid          <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // let every outstanding key event arrive, then give silent requests time to retire
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_keys.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_setting(input logic value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        rctrl_to_lalt = value;
    endtask

    initial begin
        int        gap;
        int        first;
        int        run_left;
        bit        busy_run;
        key_req_t  rq;
        key_out_t  spare;

        run_left       = 0;
        busy_run       = 1'b0;
        for (int i = 0; i < scrat_pkg::TABLE_DEPTH; i++) begin
            key_map[i] = 10'(i);
        end
        left_alt_held  = 1'b0;
        right_alt_held = 1'b0;
        tab_held       = 1'b0;
        rctrl_to_lalt  = 1'b0;

        //                  make   e0    e1    rl    ms    wn    fs
        directed = '{
            key_row(8'h1E,     1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                    TYPED, ONE_RESULT, 9'h01E),
            key_row(8'h1E,     1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
                    TYPED, ONE_RESULT, 9'h01E),
            key_row(8'hFF,     1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    TYPED, ONE_RESULT, 9'h1FF),
            key_row(8'h00,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    TYPED, ONE_RESULT, 9'h000),
            // E0 00 converts to a code that does not exist
            key_row(8'h00,     1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    TYPED, NO_RESULT, 9'h000),
            // Pause and an unknown E1 code, then both prefixes at once
            key_row(MAKE_CTRL, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                    TYPED, ONE_RESULT, scrat_pkg::CODE_E1_PAUSE),
            key_row(8'h45,     1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                    TYPED, NO_RESULT, 9'h000),
            key_row(MAKE_CTRL, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
                    TYPED, ONE_RESULT, scrat_pkg::CODE_E1_PAUSE),
            // capture pending drops the key; full screen lets it through
            key_row(8'h1E,     1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                    TYPED, NO_RESULT, 9'h000),
            key_row(8'h1E,     1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                    TYPED, ONE_RESULT, 9'h01E),
            // Alt then Tab: release burst for left Alt
            key_row(MAKE_ALT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    PREDICTED, NO_RESULT, 9'h000),
            key_row(MAKE_TAB,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    PREDICTED, NO_RESULT, 9'h000),
            // right Alt held, Tab with mouse held passes, then Alt releases Tab
            key_row(MAKE_ALT,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    PREDICTED, NO_RESULT, 9'h000),
            key_row(MAKE_TAB,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                    PREDICTED, NO_RESULT, 9'h000),
            key_row(MAKE_ALT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    PREDICTED, NO_RESULT, 9'h000),
            // both Alts held, then Tab: six results
            key_row(MAKE_ALT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    PREDICTED, NO_RESULT, 9'h000),
            key_row(MAKE_TAB,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    PREDICTED, NO_RESULT, 9'h000),
            key_row(MAKE_CTRL, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    PREDICTED, NO_RESULT, 9'h000),
            // table writes: right Ctrl to Tab, Pause to right Alt,
            // an invalid source, an invalid target
            map_row(16'hE01D, 16'h000F),
            map_row(scrat_pkg::RAW_E1_PAUSE, 16'hE038),
            map_row(scrat_pkg::RAW_E0_ZERO, 16'h0001),
            map_row(16'h0002, 16'hFFFF),
            key_row(8'h02,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    TYPED, NO_RESULT, 9'h000),
            key_row(MAKE_CTRL, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                    PREDICTED, NO_RESULT, 9'h000),
            key_row(MAKE_CTRL, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    PREDICTED, NO_RESULT, 9'h000),
            key_row(MAKE_ALT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    PREDICTED, NO_RESULT, 9'h000)
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // taken even while the table fill holds off requests
        write_setting(1'b0);

        for (int r = 0; r < NUM_DIRECTED; r++) begin
            gap = draw_pause(run_left, busy_run);
            offer_request(directed[r].req, gap);
            first = pending_keys.size();
            remap_and_filter(directed[r].req);
            if (directed[r].typed) begin
                // state follows the predictor, the check uses the typed value
                while (pending_keys.size() > first) begin
                    spare = pending_keys.pop_back();
                end
                if (directed[r].has_result) begin
                    spare.pressed  = !directed[r].req.rel;
                    spare.key_code = directed[r].code;
                    spare.last     = 1'b1;
                    pending_keys.push_back(spare);
                end
            end
        end

        for (int p = 0; p < 3; p++) begin
            settle();
            write_setting(SETTING_PLAN[p]);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                rq  = random_request();
                gap = draw_pause(run_left, busy_run);
                offer_request(rq, gap);
                remap_and_filter(rq);
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    initial begin
        int       stall;
        int       run_left;
        bit       busy_run;
        key_out_t exp_key;

        run_left = 0;
        busy_run = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_pause(run_left, busy_run);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_keys.size() == 0) begin
                mismatches++;
                $display("%0t: key event expected none, got pressed %b code %h last %b",
                         $time, m_pressed, m_key_code, m_last);
            end else begin
                exp_key = pending_keys.pop_front();
                if (m_pressed !== exp_key.pressed) begin
                    mismatches++;
                    $display("%0t: pressed expected %b, got %b",
                             $time, exp_key.pressed, m_pressed);
                end
                if (m_key_code !== exp_key.key_code) begin
                    mismatches++;
                    $display("%0t: key_code expected %h, got %h",
                             $time, exp_key.key_code, m_key_code);
                end
                if (m_last !== exp_key.last) begin
                    mismatches++;
                    $display("%0t: last expected %b, got %b", $time, exp_key.last, m_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any request or result moving
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule
